// ----- rtl/qte_pkg.sv -----
// Package for the quaternion to Euler angle pipeline.
// Holds stream widths, datapath widths and the CORDIC arctangent table.
// No dependencies.
package qte_pkg;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;

  // Vector and angle widths inside the CORDIC
  localparam int VEC_W  = 36;  // raw numerator / denominator, Q.28
  localparam int CRD_W  = 45;  // normalised and rotated vector
  localparam int MAG_W  = 42;  // magnitude word for the shift search
  localparam int ANG_W  = 26;  // angle accumulator, degrees Q.16
  localparam int N_CRD  = 20;  // CORDIC iterations
  localparam int N_SQRT = 29;  // result bits of the square root
  localparam int S_W    = 30;  // clamped asin argument
  localparam int SQ_W   = 57;  // argument squared, up to 2^56
  localparam int RT_W   = 59;  // square-root running root and trial word

  localparam int LIM_ROLL  = 23040;
  localparam int LIM_PITCH = 11520;

  // Quarter turn in the accumulator format
  localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(90 * 65536);

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:  a = ANG_W'(2949120);
      1:  a = ANG_W'(1740967);
      2:  a = ANG_W'(919879);
      3:  a = ANG_W'(466945);
      4:  a = ANG_W'(234379);
      5:  a = ANG_W'(117304);
      6:  a = ANG_W'(58666);
      7:  a = ANG_W'(29335);
      8:  a = ANG_W'(14668);
      9:  a = ANG_W'(7334);
      10: a = ANG_W'(3667);
      11: a = ANG_W'(1833);
      12: a = ANG_W'(917);
      13: a = ANG_W'(458);
      14: a = ANG_W'(229);
      15: a = ANG_W'(115);
      16: a = ANG_W'(57);
      17: a = ANG_W'(29);
      18: a = ANG_W'(14);
      19: a = ANG_W'(7);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/qte_delay.sv -----
// Fixed-length register delay line with a shared advance enable.
// Depends on nothing.
module qte_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [0:N-1];

  // shift on every advance
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[N-1];

endmodule

// ----- rtl/qte_isqrt.sv -----
// Pipelined floor square root of 2^56 - s*s, one root bit per stage.
// Carries the argument s alongside. Depends on qte_pkg.
module qte_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [qte_pkg::S_W-1:0]  in_s,
  input  logic [qte_pkg::SQ_W-1:0]    in_sq,
  output logic                        out_valid,
  output logic signed [qte_pkg::S_W-1:0]  out_s,
  output logic [qte_pkg::N_SQRT-1:0]  out_root
);
  import qte_pkg::*;

  localparam logic [RT_W-1:0] ONE_Q56 = RT_W'(1) << 56;

  logic [RT_W-1:0]       rem_r  [1:N_SQRT];
  logic [RT_W-1:0]       root_r [1:N_SQRT];
  logic signed [S_W-1:0] s_r    [1:N_SQRT];
  logic                  vld_r  [1:N_SQRT];

  genvar k;
  generate
    for (k = 0; k < N_SQRT; k++) begin : g_st
      localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (N_SQRT - 1 - k));
      logic [RT_W-1:0]       rem_i, root_i, trial;
      logic signed [S_W-1:0] s_i;
      logic                  vld_i;

      if (k == 0) begin : g_first
        assign rem_i  = ONE_Q56 - RT_W'(in_sq);
        assign root_i = '0;
        assign s_i    = in_s;
        assign vld_i  = in_valid;
      end else begin : g_next
        assign rem_i  = rem_r[k];
        assign root_i = root_r[k];
        assign s_i    = s_r[k];
        assign vld_i  = vld_r[k];
      end

      assign trial = root_i + BIT;

      // one restoring step
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else if (en) begin
          vld_r[k+1] <= vld_i;
        end
        if (en) begin
          s_r[k+1] <= s_i;
          if (rem_i >= trial) begin
            rem_r[k+1]  <= rem_i - trial;
            root_r[k+1] <= (root_i >> 1) + BIT;
          end else begin
            rem_r[k+1]  <= rem_i;
            root_r[k+1] <= root_i >> 1;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[N_SQRT];
  assign out_s     = s_r[N_SQRT];
  assign out_root  = root_r[N_SQRT][N_SQRT-1:0];

endmodule

// ----- rtl/qte_cordic.sv -----
// Pipelined atan2 in degrees: shift search, quadrant turn, 20 vectoring
// stages, round and saturate. Depends on qte_pkg.
module qte_cordic #(
  parameter int LIM = 23040
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [qte_pkg::VEC_W-1:0] in_y,
  input  logic signed [qte_pkg::VEC_W-1:0] in_x,
  output logic                           out_valid,
  output logic signed [15:0]             out_angle
);
  import qte_pkg::*;

  localparam int N_NORM = 6;
  localparam logic signed [16:0] LIM_P = 17'(LIM);
  localparam logic signed [16:0] LIM_N = -17'(LIM);

  // magnitude OR for the shift search
  logic [VEC_W-1:0] ax, ay;
  assign ax = in_x[VEC_W-1] ? VEC_W'(-in_x) : VEC_W'(in_x);
  assign ay = in_y[VEC_W-1] ? VEC_W'(-in_y) : VEC_W'(in_y);

  logic signed [CRD_W-1:0] nx_r [0:N_NORM];
  logic signed [CRD_W-1:0] ny_r [0:N_NORM];
  logic [MAG_W-1:0]        nm_r [0:N_NORM];
  logic                    nz_r [0:N_NORM];
  logic                    nv_r [0:N_NORM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r[0] <= 1'b0;
    end else if (en) begin
      nv_r[0] <= in_valid;
    end
    if (en) begin
      nx_r[0] <= CRD_W'(in_x);
      ny_r[0] <= CRD_W'(in_y);
      nm_r[0] <= MAG_W'(ax | ay);
      nz_r[0] <= (in_x == '0) && (in_y == '0);
    end
  end

  // binary shift search: bring the larger magnitude to [2^40, 2^41)
  genvar j;
  generate
    for (j = 0; j < N_NORM; j++) begin : g_norm
      localparam int SH = 1 << (N_NORM - 1 - j);
      localparam logic [MAG_W-1:0] THR = MAG_W'(1) << (41 - SH);
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          nv_r[j+1] <= 1'b0;
        end else if (en) begin
          nv_r[j+1] <= nv_r[j];
        end
        if (en) begin
          nz_r[j+1] <= nz_r[j];
          if (nm_r[j] < THR) begin
            nx_r[j+1] <= nx_r[j] <<< SH;
            ny_r[j+1] <= ny_r[j] <<< SH;
            nm_r[j+1] <= nm_r[j] << SH;
          end else begin
            nx_r[j+1] <= nx_r[j];
            ny_r[j+1] <= ny_r[j];
            nm_r[j+1] <= nm_r[j];
          end
        end
      end
    end
  endgenerate

  logic signed [CRD_W-1:0] cx_r [0:N_CRD];
  logic signed [CRD_W-1:0] cy_r [0:N_CRD];
  logic signed [ANG_W-1:0] cz_r [0:N_CRD];
  logic                    cw_r [0:N_CRD];  // zero vector flag
  logic                    cv_r [0:N_CRD];

  // quadrant turn for vectors in the left half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= nv_r[N_NORM];
    end
    if (en) begin
      cw_r[0] <= nz_r[N_NORM];
      if (nx_r[N_NORM] < 0) begin
        if (ny_r[N_NORM] >= 0) begin
          cx_r[0] <= ny_r[N_NORM];
          cy_r[0] <= -nx_r[N_NORM];
          cz_r[0] <= ANG_90;
        end else begin
          cx_r[0] <= -ny_r[N_NORM];
          cy_r[0] <= nx_r[N_NORM];
          cz_r[0] <= -ANG_90;
        end
      end else begin
        cx_r[0] <= nx_r[N_NORM];
        cy_r[0] <= ny_r[N_NORM];
        cz_r[0] <= '0;
      end
    end
  end

  // vectoring iterations
  genvar i;
  generate
    for (i = 0; i < N_CRD; i++) begin : g_crd
      localparam logic signed [ANG_W-1:0] ATN = atan_q16(i);
      logic signed [CRD_W-1:0] dx, dy;
      assign dx = cx_r[i] >>> i;
      assign dy = cy_r[i] >>> i;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cv_r[i+1] <= 1'b0;
        end else if (en) begin
          cv_r[i+1] <= cv_r[i];
        end
        if (en) begin
          cw_r[i+1] <= cw_r[i];
          if (cy_r[i] > 0) begin
            cx_r[i+1] <= cx_r[i] + dy;
            cy_r[i+1] <= cy_r[i] - dx;
            cz_r[i+1] <= cz_r[i] + ATN;
          end else begin
            cx_r[i+1] <= cx_r[i] - dy;
            cy_r[i+1] <= cy_r[i] + dx;
            cz_r[i+1] <= cz_r[i] - ATN;
          end
        end
      end
    end
  endgenerate

  // round to 7 fraction bits and saturate
  logic signed [ANG_W-1:0] zr;
  logic signed [16:0]      rnd;
  logic signed [15:0]      ang_nxt;
  logic signed [15:0]      ang_r;
  logic                    vo_r;

  assign zr  = cz_r[N_CRD] + ANG_W'(256);
  assign rnd = 17'(zr >>> 9);

  always_comb begin
    if (cw_r[N_CRD]) begin
      ang_nxt = '0;
    end else if (rnd > LIM_P) begin
      ang_nxt = LIM_P[15:0];
    end else if (rnd < LIM_N) begin
      ang_nxt = LIM_N[15:0];
    end else begin
      ang_nxt = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= cv_r[N_CRD];
    end
    if (en) begin
      ang_r <= ang_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_angle = ang_r;

endmodule

// ----- rtl/quaternion_to_euler_degrees_top.sv -----
// Quaternion (Q1.14) to roll, pitch, yaw in degrees (7 fraction bits).
// One item per cycle. Pitch sets the latency: products, sums, square,
// 29-stage square root, then the 29-stage CORDIC; roll and yaw are
// delayed to match.
// The whole pipeline stalls together while a result waits at the output.
// Synchronous active-low reset clears the valid bits only.
module quaternion_to_euler_degrees_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sensor_id[3:0], quat_w[19:4], quat_x[35:20], quat_y[51:36], quat_z[67:52]
  input  logic [qte_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sensor_tag[3:0], roll_deg[19:4], pitch_deg[34:20], yaw_deg[50:35]
  output logic [qte_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import qte_pkg::*;

  localparam logic signed [VEC_W-1:0] ONE_Q28 = VEC_W'(1) <<< 28;
  localparam logic signed [VEC_W-1:0] S_MAX   = ONE_Q28;
  localparam logic signed [VEC_W-1:0] S_MIN   = -ONE_Q28;
  localparam int ID_DLY = 1 + N_SQRT + 29;
  localparam int RY_DLY = 1 + N_SQRT;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [3:0]         id_in;
  logic signed [15:0] qw, qx, qy, qz;
  assign id_in = in_tdata[3:0];
  assign qw    = in_tdata[19:4];
  assign qx    = in_tdata[35:20];
  assign qy    = in_tdata[51:36];
  assign qz    = in_tdata[67:52];

  // stage 1: products
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  logic [3:0]         id1_r;
  logic               v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
    if (en) begin
      id1_r <= id_in;
      wx_r  <= qw * qx;
      yz_r  <= qy * qz;
      xx_r  <= qx * qx;
      yy_r  <= qy * qy;
      wz_r  <= qw * qz;
      xy_r  <= qx * qy;
      zz_r  <= qz * qz;
      wy_r  <= qw * qy;
      zx_r  <= qz * qx;
    end
  end

  // stage 2: numerators, denominators, clamped asin argument
  logic signed [VEC_W-1:0] rn_nxt, rd_nxt, yn_nxt, yd_nxt, s_raw;
  logic signed [S_W-1:0]   s_nxt;

  always_comb begin
    rn_nxt = (VEC_W'(wx_r) + VEC_W'(yz_r)) <<< 1;
    rd_nxt = ONE_Q28 - ((VEC_W'(xx_r) + VEC_W'(yy_r)) <<< 1);
    yn_nxt = (VEC_W'(wz_r) + VEC_W'(xy_r)) <<< 1;
    yd_nxt = ONE_Q28 - ((VEC_W'(yy_r) + VEC_W'(zz_r)) <<< 1);
    s_raw  = (VEC_W'(wy_r) - VEC_W'(zx_r)) <<< 1;
    if (s_raw > S_MAX) begin
      s_nxt = S_MAX[S_W-1:0];
    end else if (s_raw < S_MIN) begin
      s_nxt = S_MIN[S_W-1:0];
    end else begin
      s_nxt = s_raw[S_W-1:0];
    end
  end

  logic signed [VEC_W-1:0] rn_r, rd_r, yn_r, yd_r;
  logic signed [S_W-1:0]   s2_r;
  logic [3:0]              id2_r;
  logic                    v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      id2_r <= id1_r;
      rn_r  <= rn_nxt;
      rd_r  <= rd_nxt;
      yn_r  <= yn_nxt;
      yd_r  <= yd_nxt;
      s2_r  <= s_nxt;
    end
  end

  // stage 3: square of the asin argument
  logic signed [2*S_W-1:0] sq_full;
  logic [SQ_W-1:0]         sq_r;
  logic signed [S_W-1:0]   s3_r;
  logic                    v3_r;

  assign sq_full = s2_r * s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      s3_r <= s2_r;
      sq_r <= sq_full[SQ_W-1:0];
    end
  end

  // pitch: square root then CORDIC
  logic                  sv;
  logic signed [S_W-1:0] s_sq;
  logic [N_SQRT-1:0]     c_sq;

  qte_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v3_r),
    .in_s     (s3_r),
    .in_sq    (sq_r),
    .out_valid(sv),
    .out_s    (s_sq),
    .out_root (c_sq)
  );

  logic               pv;
  logic signed [15:0] pitch;

  qte_cordic #(.LIM(LIM_PITCH)) u_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sv),
    .in_y     (VEC_W'(s_sq)),
    .in_x     (VEC_W'({1'b0, c_sq})),
    .out_valid(pv),
    .out_angle(pitch)
  );

  // roll and yaw CORDICs, then delay to line up with pitch
  logic               rv, yv;
  logic signed [15:0] roll, yaw;

  qte_cordic #(.LIM(LIM_ROLL)) u_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v2_r),
    .in_y     (rn_r),
    .in_x     (rd_r),
    .out_valid(rv),
    .out_angle(roll)
  );

  qte_cordic #(.LIM(LIM_ROLL)) u_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v2_r),
    .in_y     (yn_r),
    .in_x     (yd_r),
    .out_valid(yv),
    .out_angle(yaw)
  );

  logic [31:0] ry_d;

  qte_delay #(.W(32), .N(RY_DLY)) u_ry_dly (
    .clk (clk),
    .en  (en),
    .din ({yaw, roll}),
    .dout(ry_d)
  );

  logic [3:0] id_d;

  qte_delay #(.W(4), .N(ID_DLY)) u_id_dly (
    .clk (clk),
    .en  (en),
    .din (id2_r),
    .dout(id_d)
  );

  // roll and yaw valids are unused; pitch's is the one that leaves
  logic unused_v;
  assign unused_v = rv ^ yv;

  assign out_tvalid = pv;
  assign out_tdata  = {5'b0, ry_d[31:16], pitch[14:0], ry_d[15:0], id_d};

endmodule
